>>> hw/rtl/utf8v_pkg.sv
// shared types and constants for the utf-8 tsv field validator
`default_nettype none

package utf8v_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned PEND_W    = 2;
   localparam int unsigned VERDICT_W = 2;
   localparam int unsigned RSP_TDATA_W = 8;

   localparam logic [VERDICT_W-1:0] VERDICT_OK       = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_BAD_UTF8 = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_CTRL     = 2'd2;

   localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_TAB = 8'h09;
   localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0a;
   localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0d;

   localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7f;
   localparam logic [BYTE_W-1:0] CONT_LOW   = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_HIGH  = 8'hbf;
   localparam logic [BYTE_W-1:0] LEAD2_LOW  = 8'hc2;
   localparam logic [BYTE_W-1:0] LEAD2_HIGH = 8'hdf;
   localparam logic [BYTE_W-1:0] LEAD_E0    = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD_ED    = 8'hed;
   localparam logic [BYTE_W-1:0] LEAD3_HIGH = 8'hef;
   localparam logic [BYTE_W-1:0] LEAD_F0    = 8'hf0;
   localparam logic [BYTE_W-1:0] LEAD_F4    = 8'hf4;
   localparam logic [BYTE_W-1:0] E0_LOW     = 8'ha0;
   localparam logic [BYTE_W-1:0] ED_HIGH    = 8'h9f;
   localparam logic [BYTE_W-1:0] F0_LOW     = 8'h90;
   localparam logic [BYTE_W-1:0] F4_HIGH    = 8'h8f;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              byte_present;
      logic              end_of_field;
   } beat_type;

   typedef struct packed {
      logic                 valid;
      logic [VERDICT_W-1:0] verdict;
   } result_type;

endpackage

`default_nettype wire

>>> hw/rtl/utf8v_in_stage.sv
// input register stage for request beats
`default_nettype none

module utf8v_in_stage
   import utf8v_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire beat_type req_beat,
   input  wire logic     consume,
   output logic          beat_valid,
   output beat_type      beat
);

   logic     valid_ff;
   logic     valid_in;
   beat_type beat_ff;
   logic     load;

   assign req_tready = !valid_ff || consume;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= req_beat;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

`default_nettype wire

>>> hw/rtl/utf8v_checker.sv
// running utf-8 and control byte check with per-field verdict
`default_nettype none

module utf8v_checker
   import utf8v_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     beat_valid,
   input  wire beat_type beat,
   input  wire logic     out_free,
   output logic          consume,
   output result_type    result
);

   logic [PEND_W-1:0] pending_ff, pending_in;
   logic [BYTE_W-1:0] low_ff, low_in;
   logic [BYTE_W-1:0] high_ff, high_in;
   logic              expecting_ff, expecting_in;
   logic              err_ff, err_in;
   logic              ctrl_ff, ctrl_in;

   logic [BYTE_W-1:0] b;
   logic [BYTE_W-1:0] win_low;
   logic [BYTE_W-1:0] win_high;
   logic              out_of_window;

   assign b       = beat.data_byte;
   assign consume = beat_valid && (!beat.end_of_field || out_free);

   always_comb begin
      pending_in    = pending_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      expecting_in  = expecting_ff;
      err_in        = err_ff;
      ctrl_in       = ctrl_ff;
      win_low       = expecting_ff ? low_ff : CONT_LOW;
      win_high      = expecting_ff ? high_ff : CONT_HIGH;
      out_of_window = (b < win_low) || (b > win_high);
      result.valid   = beat_valid && beat.end_of_field;
      result.verdict = VERDICT_OK;

      if (beat.byte_present) begin
         if (b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR || b == BYTE_NUL) begin
            ctrl_in = 1'b1;
         end
         if (pending_ff != '0) begin
            if (out_of_window) begin
               err_in     = 1'b1;
               pending_in = '0;
            end else begin
               pending_in = pending_ff - PEND_W'(1);
            end
            expecting_in = 1'b0;
            low_in       = CONT_LOW;
            high_in      = CONT_HIGH;
         end else begin
            priority if (b <= ASCII_MAX) begin
               err_in = err_ff;
            end else if (b >= LEAD2_LOW && b <= LEAD2_HIGH) begin
               pending_in = PEND_W'(1); low_in = CONT_LOW; high_in = CONT_HIGH;
               expecting_in = 1'b1;
            end else if (b == LEAD_E0) begin
               pending_in = PEND_W'(2); low_in = E0_LOW; high_in = CONT_HIGH;
               expecting_in = 1'b1;
            end else if (b == LEAD_ED) begin
               pending_in = PEND_W'(2); low_in = CONT_LOW; high_in = ED_HIGH;
               expecting_in = 1'b1;
            end else if (b > LEAD_E0 && b <= LEAD3_HIGH) begin
               pending_in = PEND_W'(2); low_in = CONT_LOW; high_in = CONT_HIGH;
               expecting_in = 1'b1;
            end else if (b == LEAD_F0) begin
               pending_in = PEND_W'(3); low_in = F0_LOW; high_in = CONT_HIGH;
               expecting_in = 1'b1;
            end else if (b == LEAD_F4) begin
               pending_in = PEND_W'(3); low_in = CONT_LOW; high_in = F4_HIGH;
               expecting_in = 1'b1;
            end else if (b > LEAD_F0 && b < LEAD_F4) begin
               pending_in = PEND_W'(3); low_in = CONT_LOW; high_in = CONT_HIGH;
               expecting_in = 1'b1;
            end else begin
               err_in = 1'b1;
            end
         end
      end

      if (beat.end_of_field) begin
         if (err_in || pending_in != '0) begin
            result.verdict = VERDICT_BAD_UTF8;
         end else if (ctrl_in) begin
            result.verdict = VERDICT_CTRL;
         end
         pending_in   = '0;
         low_in       = CONT_LOW;
         high_in      = CONT_HIGH;
         expecting_in = 1'b0;
         err_in       = 1'b0;
         ctrl_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         low_ff       <= CONT_LOW;
         high_ff      <= CONT_HIGH;
         expecting_ff <= 1'b0;
         err_ff       <= 1'b0;
         ctrl_ff      <= 1'b0;
      end else if (consume) begin
         pending_ff   <= pending_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         expecting_ff <= expecting_in;
         err_ff       <= err_in;
         ctrl_ff      <= ctrl_in;
      end
   end

   // second-byte window only armed while a sequence is open
   a_expect_needs_pending: assert property (@(posedge clock) disable iff (reset)
      expecting_ff |-> (pending_ff != '0))
      else $error("second-byte window armed with no pending continuation");

   a_window_default: assert property (@(posedge clock) disable iff (reset)
      !expecting_ff |-> (low_ff == CONT_LOW && high_ff == CONT_HIGH))
      else $error("narrowed window left over after second byte");

   a_field_clears: assert property (@(posedge clock) disable iff (reset)
      (consume && beat.end_of_field) |=> (pending_ff == '0 && !err_ff && !ctrl_ff))
      else $error("field state not cleared after verdict");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (result.verdict == VERDICT_OK || result.verdict == VERDICT_BAD_UTF8
                        || result.verdict == VERDICT_CTRL))
      else $error("unused verdict code produced");

endmodule

`default_nettype wire

>>> hw/rtl/utf8v_out_stage.sv
// output register holding one verdict beat
`default_nettype none

module utf8v_out_stage
   import utf8v_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic [VERDICT_W-1:0] verdict,
   output logic                   out_free,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic                 valid_ff, valid_in;
   logic [VERDICT_W-1:0] verdict_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-VERDICT_W){1'b0}}, verdict_ff};

endmodule

`default_nettype wire

>>> hw/rtl/utf8_tsv_field_validator.sv
// top level of the strict utf-8 and tsv field validator
//
// req channel: one beat per field byte; tdata carries the byte, tuser[0] says
// the byte is present, tlast marks the last beat of the field. a beat with
// tuser low and tlast high ends a field without a byte (empty field allowed);
// tuser and tlast both low is an idle beat that changes nothing.
// rsp channel: one beat per field, sent for the tlast beat; tdata[1:0] holds
// the verdict: 0 ok, 1 invalid or truncated utf-8, 2 tab/lf/cr/nul present.
// invalid utf-8 outranks a control byte.
// a tlast beat passes from the input register through the running-state update
// into the verdict register, whose output drives rsp.
// throughput: one beat per cycle while no tlast beat waits for the verdict slot.
// when rsp stalls, the verdict is held and beats without tlast keep flowing;
// a tlast beat waits in the input register until the verdict slot frees.
// reset empties both registers and clears all per-field state; no field is open.
`default_nettype none

module utf8_tsv_field_validator
   import utf8v_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,   // data_byte
   input  wire logic                   req_tuser,   // byte_present
   input  wire logic                   req_tlast,   // end_of_field
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata    // verdict [1:0], zeros above
);

   beat_type   req_beat;
   beat_type   beat;
   logic       beat_valid;
   logic       consume;
   logic       out_free;
   result_type result;

   assign req_beat.data_byte    = req_tdata;
   assign req_beat.byte_present = req_tuser;
   assign req_beat.end_of_field = req_tlast;

   utf8v_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_beat   (req_beat),
      .consume    (consume),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   utf8v_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat       (beat),
      .out_free   (out_free),
      .consume    (consume),
      .result     (result)
   );

   utf8v_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (consume && result.valid),
      .verdict    (result.verdict),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// testbench for the strict utf-8 and tsv field validator
`default_nettype none

module tb;
   import utf8v_pkg::*;

   localparam int unsigned FIELD_BEATS = 1800;
   localparam int unsigned CYCLE_LIMIT = 500000;

   class field_verdict_board;
      logic [PEND_W-1:0]    conts_left;
      logic [BYTE_W-1:0]    second_lo;
      logic [BYTE_W-1:0]    second_hi;
      bit                   second_next;
      bit                   bad_utf8;
      bit                   ctrl_seen;
      logic [VERDICT_W-1:0] expected_verdicts[$];
      int unsigned          failures;

      function new();
         clear_field();
         failures = 0;
      endfunction

      function void clear_field();
         conts_left  = '0;
         second_lo   = CONT_LOW;
         second_hi   = CONT_HIGH;
         second_next = 1'b0;
         bad_utf8    = 1'b0;
         ctrl_seen   = 1'b0;
      endfunction

      function void open_sequence(int unsigned count, logic [BYTE_W-1:0] lo,
                                  logic [BYTE_W-1:0] hi);
         conts_left  = count[PEND_W-1:0];
         second_lo   = lo;
         second_hi   = hi;
         second_next = 1'b1;
      endfunction

      function int unsigned outstanding();
         return expected_verdicts.size();
      endfunction

      function void note_beat(logic [BYTE_W-1:0] data_byte, logic present, logic last);
         logic [BYTE_W-1:0]    lo;
         logic [BYTE_W-1:0]    hi;
         logic [VERDICT_W-1:0] verdict;
         if (present) begin
            if (data_byte == BYTE_NUL || data_byte == BYTE_TAB ||
                data_byte == BYTE_LF || data_byte == BYTE_CR)
               ctrl_seen = 1'b1;
            if (conts_left != 0) begin
               lo = second_next ? second_lo : CONT_LOW;
               hi = second_next ? second_hi : CONT_HIGH;
               if (data_byte < lo || data_byte > hi) begin
                  bad_utf8   = 1'b1;
                  conts_left = '0;
               end else begin
                  conts_left = conts_left - 1'b1;
               end
               second_next = 1'b0;
               second_lo   = CONT_LOW;
               second_hi   = CONT_HIGH;
            end else if (data_byte > ASCII_MAX) begin
               if (data_byte >= LEAD2_LOW && data_byte <= LEAD2_HIGH)
                  open_sequence(1, CONT_LOW, CONT_HIGH);
               else if (data_byte == LEAD_E0)
                  open_sequence(2, E0_LOW, CONT_HIGH);
               else if (data_byte == LEAD_ED)
                  open_sequence(2, CONT_LOW, ED_HIGH);
               else if (data_byte > LEAD_E0 && data_byte <= LEAD3_HIGH)
                  open_sequence(2, CONT_LOW, CONT_HIGH);
               else if (data_byte == LEAD_F0)
                  open_sequence(3, F0_LOW, CONT_HIGH);
               else if (data_byte == LEAD_F4)
                  open_sequence(3, CONT_LOW, F4_HIGH);
               else if (data_byte > LEAD_F0 && data_byte < LEAD_F4)
                  open_sequence(3, CONT_LOW, CONT_HIGH);
               else
                  bad_utf8 = 1'b1;
            end
         end
         if (last) begin
            if (conts_left != 0)
               bad_utf8 = 1'b1;
            if (bad_utf8)
               verdict = VERDICT_BAD_UTF8;
            else if (ctrl_seen)
               verdict = VERDICT_CTRL;
            else
               verdict = VERDICT_OK;
            expected_verdicts = {expected_verdicts, verdict};
            clear_field();
         end
      endfunction

      function void check_verdict(logic [RSP_TDATA_W-1:0] tdata);
         logic [VERDICT_W-1:0] want;
         if (expected_verdicts.size() == 0) begin
            $error("verdict: no field pending, got %0d", tdata[VERDICT_W-1:0]);
            failures++;
            return;
         end
         want = expected_verdicts.pop_front();
         if (tdata[VERDICT_W-1:0] !== want) begin
            $error("verdict: expected %0d, got %0d", want, tdata[VERDICT_W-1:0]);
            failures++;
         end
         if (tdata[RSP_TDATA_W-1:VERDICT_W] !== '0) begin
            $error("rsp_tdata padding: expected 0, got %0h", tdata[RSP_TDATA_W-1:VERDICT_W]);
            failures++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata;   // data_byte
   logic                   req_tuser;   // byte_present
   logic                   req_tlast;   // end_of_field
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // verdict [1:0], zeros above

   field_verdict_board verdicts;
   logic [BYTE_W-1:0]  field_bytes[$];
   bit                 quiet;
   int unsigned        cycle_count = 0;

   utf8_tsv_field_validator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            verdicts.check_verdict(rsp_tdata);
         if (req_tvalid && req_tready)
            verdicts.note_beat(req_tdata, req_tuser, req_tlast);
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_beat(logic [BYTE_W-1:0] data_byte, logic present, logic last);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = data_byte;
      req_tuser  = present;
      req_tlast  = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_all_verdicts();
      while (verdicts.outstanding() != 0)
         @(negedge clock);
   endtask

   // one character, usually well formed, sometimes broken at an edge of its window
   task automatic add_char();
      logic [BYTE_W-1:0] lead;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] b;
      int unsigned       r;
      int unsigned       len;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         b = BYTE_W'($urandom_range(8'h20, 8'h7e));
         field_bytes = {field_bytes, b};
         return;
      end
      if (r < 36) begin
         case ($urandom_range(0, 4))
            0: b = BYTE_NUL;
            1: b = BYTE_TAB;
            2: b = BYTE_LF;
            3: b = BYTE_CR;
            default: b = BYTE_W'($urandom_range(0, ASCII_MAX));
         endcase
         field_bytes = {field_bytes, b};
         return;
      end
      if (r < 42) begin
         b = BYTE_W'($urandom_range(8'h80, 8'hff));
         field_bytes = {field_bytes, b};
         return;
      end
      len = $urandom_range(2, 4);
      lo  = CONT_LOW;
      hi  = CONT_HIGH;
      case (len)
         2: lead = BYTE_W'($urandom_range(LEAD2_LOW, LEAD2_HIGH));
         3: begin
            r = $urandom_range(0, 9);
            if (r < 2)
               lead = LEAD_E0;
            else if (r < 4)
               lead = LEAD_ED;
            else
               lead = BYTE_W'($urandom_range(LEAD_E0, LEAD3_HIGH));
         end
         default: lead = BYTE_W'($urandom_range(LEAD_F0, LEAD_F4));
      endcase
      if (lead == LEAD_E0)
         lo = E0_LOW;
      if (lead == LEAD_ED)
         hi = ED_HIGH;
      if (lead == LEAD_F0)
         lo = F0_LOW;
      if (lead == LEAD_F4)
         hi = F4_HIGH;
      field_bytes = {field_bytes, lead};
      r = $urandom_range(0, 99);
      if (r < 12)
         b = r[0] ? lo : hi;
      else if (r < 18)
         b = r[0] ? lo - 1'b1 : hi + 1'b1;
      else
         b = BYTE_W'($urandom_range(hi, lo));
      field_bytes = {field_bytes, b};
      repeat (len - 2) begin
         if ($urandom_range(0, 24) == 0)
            b = BYTE_W'($urandom_range(0, 8'hff));
         else
            b = BYTE_W'($urandom_range(CONT_HIGH, CONT_LOW));
         field_bytes = {field_bytes, b};
      end
      if ($urandom_range(0, 19) == 0)
         void'(field_bytes.pop_back());
   endtask

   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         int unsigned stall;
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   initial begin
      int unsigned sent;
      int unsigned field_no;
      int unsigned nchars;
      bit          bare_end;
      logic [BYTE_W-1:0] b;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      quiet      = 1'b0;
      verdicts   = new();
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // empty field
      send_beat(8'h00, 1'b0, 1'b1);
      // tab on the closing beat
      send_beat(8'h41, 1'b1, 1'b0);
      send_beat(BYTE_TAB, 1'b1, 1'b1);
      // highest code point
      send_beat(LEAD_F4, 1'b1, 1'b0);
      send_beat(F4_HIGH, 1'b1, 1'b0);
      send_beat(CONT_HIGH, 1'b1, 1'b0);
      send_beat(CONT_HIGH, 1'b1, 1'b1);
      // overlong three-byte form and a nul: encoding error wins
      send_beat(LEAD_E0, 1'b1, 1'b0);
      send_beat(8'h9f, 1'b1, 1'b0);
      send_beat(BYTE_NUL, 1'b1, 1'b1);
      // idle beat in the middle of a sequence
      send_beat(LEAD2_LOW, 1'b1, 1'b0);
      send_beat(8'hff, 1'b0, 1'b0);
      send_beat(CONT_LOW, 1'b1, 1'b1);
      // truncated four-byte sequence
      send_beat(LEAD_F0, 1'b1, 1'b0);
      send_beat(F0_LOW, 1'b1, 1'b1);
      // surrogate
      send_beat(LEAD_ED, 1'b1, 1'b0);
      send_beat(8'ha0, 1'b1, 1'b1);
      // bad lead bytes, closed by a bare end
      send_beat(8'hc1, 1'b1, 1'b0);
      send_beat(8'hf5, 1'b1, 1'b0);
      send_beat(8'hff, 1'b0, 1'b1);
      // lf, cr and del, closed by a bare end
      send_beat(BYTE_LF, 1'b1, 1'b0);
      send_beat(BYTE_CR, 1'b1, 1'b0);
      send_beat(ASCII_MAX, 1'b1, 1'b0);
      send_beat(8'hff, 1'b0, 1'b1);

      sent     = 0;
      field_no = 0;
      while (sent < FIELD_BEATS) begin
         quiet = (field_no % 40) < 4;
         field_bytes.delete();
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               b = BYTE_W'($urandom_range(0, 8'hff));
               field_bytes = {field_bytes, b};
            end
         end else begin
            nchars = $urandom_range(0, 6);
            repeat (nchars) add_char();
         end
         bare_end = field_bytes.size() == 0 || $urandom_range(0, 9) == 0;
         foreach (field_bytes[i]) begin
            if ($urandom_range(0, 19) == 0)
               send_beat(BYTE_W'($urandom_range(0, 8'hff)), 1'b0, 1'b0);
            send_beat(field_bytes[i], 1'b1, !bare_end && i == field_bytes.size() - 1);
         end
         if (bare_end)
            send_beat(BYTE_W'($urandom_range(0, 8'hff)), 1'b0, 1'b1);
         sent += field_bytes.size() + bare_end;
         field_no++;
         if (field_no % 150 == 75) begin
            req_tvalid = 1'b0;
            wait_all_verdicts();
         end
      end

      req_tvalid = 1'b0;
      quiet      = 1'b0;
      wait_all_verdicts();
      repeat (8) @(negedge clock);
      if (verdicts.failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/utf8v_pkg.sv
hw/rtl/utf8v_in_stage.sv
hw/rtl/utf8v_checker.sv
hw/rtl/utf8v_out_stage.sv
hw/rtl/utf8_tsv_field_validator.sv
tb/sv/tb.sv
